FILE: hw/rtl/lis_pkg.sv
// shared types for the longest increasing subsequence core
// no dependencies; imported by the top level
`default_nettype none

package lis_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUERY,
        ST_LEAF,
        ST_UPDATE,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/lis_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module lis_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2047,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/longest_increasing_subsequence_length_core.sv
// longest strictly increasing subsequence length over a stream of values
// keeps a max segment tree indexed by value in one lis_ram; uses lis_pkg
//
// input channel: i_valid / o_ready carry i_sample_value, one word per item.
// output channel: o_valid / i_ready carry o_length_ending_here (longest run
// ending at this item) and o_longest_so_far (tree root), one word per item.
// each item walks the tree twice: a prefix max query that steps down one
// level at a time and reads the left child wherever the value branches
// right, then the leaf write and an upward pass that reads one sibling and
// writes one parent per level.
// all of this goes through the single tree ram, so an item is finished and
// its result handed to the output register before the next word is taken;
// o_ready is high only while idle.
// after reset the tree is swept to zero, one node per cycle, over all
// 2^(VALUE_BITS+1) - 1 nodes (2047 at the defaults); o_ready stays low.
// the result sits in an output register, so a new word is taken while the
// previous result waits; a finished item holds in place until that register
// frees up when the receiver stalls.
`default_nettype none

module longest_increasing_subsequence_length_core #(
    parameter int VALUE_BITS  = 10,
    parameter int LENGTH_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [VALUE_BITS-1:0]  i_sample_value,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic      [LENGTH_BITS-1:0] o_length_ending_here,
    output logic      [LENGTH_BITS-1:0] o_longest_so_far
);

    import lis_pkg::*;

    localparam int NB    = VALUE_BITS + 1;
    localparam int NODES = 2 * (2 ** VALUE_BITS) - 1;
    localparam int LW    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    t_state r_state, n_state;

    logic [NB-1:0]          r_clr,  n_clr;
    logic [NB-1:0]          r_node, n_node;
    logic [VALUE_BITS-1:0]  r_vs,   n_vs;
    logic [LW-1:0]          r_lvl,  n_lvl;
    logic                   r_pend, n_pend;
    logic [LENGTH_BITS-1:0] r_acc,  n_acc;
    logic [LENGTH_BITS-1:0] r_cur,  n_cur;
    logic [LENGTH_BITS-1:0] r_len,  n_len;
    logic [LENGTH_BITS-1:0] r_root, n_root;
    logic                   r_o_valid, n_o_valid;
    logic [LENGTH_BITS-1:0] r_o_len,   n_o_len;
    logic [LENGTH_BITS-1:0] r_o_root,  n_o_root;

    logic                   w_wr_en, w_rd_en;
    logic [NB-1:0]          w_wr_addr, w_rd_addr;
    logic [LENGTH_BITS-1:0] w_wr_data, w_rd_data;

    logic [NB-1:0]          w_left, w_right, w_parent, w_sib, w_dec;
    logic [LENGTH_BITS-1:0] w_best, w_leaf_len, w_upd;
    logic                   w_accept, w_out_free;

    lis_ram #(
        .WIDTH (LENGTH_BITS),
        .DEPTH (NODES)
    ) u_tree (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_ready              = (r_state == ST_IDLE);
    assign o_valid              = r_o_valid;
    assign o_length_ending_here = r_o_len;
    assign o_longest_so_far     = r_o_root;

    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_o_valid || i_ready;

    // tree index arithmetic in heap order
    assign w_left   = {r_node[NB-2:0], 1'b1};
    assign w_right  = w_left + NB'(1);
    assign w_dec    = r_node - NB'(1);
    assign w_parent = {1'b0, w_dec[NB-1:1]};
    assign w_sib    = r_node[0] ? (r_node + NB'(1)) : w_dec;

    // left child read issued last cycle folds into the prefix max
    assign w_best     = (r_pend && (w_rd_data > r_acc)) ? w_rd_data : r_acc;
    assign w_leaf_len = (&w_best) ? w_best : (w_best + LENGTH_BITS'(1));
    assign w_upd      = (w_rd_data > r_cur) ? w_rd_data : r_cur;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == NB'(NODES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_QUERY;
                end
            end
            ST_QUERY: begin
                if (r_lvl == '0) begin
                    n_state = ST_LEAF;
                end
            end
            ST_LEAF: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (r_node == '0) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_clr     = r_clr;
        n_node    = r_node;
        n_vs      = r_vs;
        n_lvl     = r_lvl;
        n_pend    = 1'b0;
        n_acc     = r_acc;
        n_cur     = r_cur;
        n_len     = r_len;
        n_root    = r_root;
        n_o_valid = r_o_valid && !i_ready;
        n_o_len   = r_o_len;
        n_o_root  = r_o_root;
        w_wr_en   = 1'b0;
        w_wr_addr = r_node;
        w_wr_data = w_upd;
        w_rd_en   = 1'b0;
        w_rd_addr = w_sib;
        case (r_state)
            ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr;
                w_wr_data = '0;
                n_clr     = r_clr + NB'(1);
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_vs   = i_sample_value;
                    n_node = '0;
                    n_lvl  = LW'(VALUE_BITS - 1);
                    n_acc  = '0;
                end
            end
            ST_QUERY: begin
                // msb of the shifted value picks the branch at this level
                n_acc  = w_best;
                n_pend = r_vs[VALUE_BITS-1];
                n_vs   = r_vs << 1;
                n_lvl  = r_lvl - LW'(1);
                if (r_vs[VALUE_BITS-1]) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_left;
                    n_node    = w_right;
                end else begin
                    n_node = w_left;
                end
            end
            ST_LEAF: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_leaf_len;
                w_rd_en   = 1'b1;
                n_len     = w_leaf_len;
                n_cur     = w_leaf_len;
                n_node    = w_parent;
            end
            ST_UPDATE: begin
                // parent takes max of the fresh child and its sibling
                w_wr_en = 1'b1;
                if (r_node == '0) begin
                    n_root = w_upd;
                end else begin
                    w_rd_en = 1'b1;
                    n_cur   = w_upd;
                    n_node  = w_parent;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_len   = r_len;
                    n_o_root  = r_root;
                end
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
        r_node   <= n_node;
        r_vs     <= n_vs;
        r_lvl    <= n_lvl;
        r_acc    <= n_acc;
        r_cur    <= n_cur;
        r_len    <= n_len;
        r_root   <= n_root;
        r_o_len  <= n_o_len;
        r_o_root <= n_o_root;
    end

endmodule

`default_nettype wire

FILE: sim/longest_increasing_subsequence_length_core_tb.sv
// self-checking bench for longest_increasing_subsequence_length_core
// tracks the best run ending at each value and checks every result word
// needs the core rtl, the lis_ram it instantiates and lis_pkg it compiles against

module longest_increasing_subsequence_length_core_tb;

    localparam int VALUE_BITS  = 10;
    localparam int LENGTH_BITS = 16;
    localparam int VALUE_COUNT = 1 << VALUE_BITS;
    localparam int VALUE_MAX   = VALUE_COUNT - 1;
    localparam int ITEM_CYCLES = 2 * VALUE_BITS + 3;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic [VALUE_BITS-1:0]  value_t;
    typedef logic [LENGTH_BITS-1:0] length_t;

    typedef struct packed {
        length_t length_ending_here;
        length_t longest_so_far;
    } run_lengths_t;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    value_t  i_sample_value;
    logic    o_valid;
    logic    i_ready;
    length_t o_length_ending_here;
    length_t o_longest_so_far;

    longest_increasing_subsequence_length_core #(
        .VALUE_BITS (VALUE_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_sample_value      (i_sample_value),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_length_ending_here(o_length_ending_here),
        .o_longest_so_far    (o_longest_so_far)
    );

    // best increasing run ending at each value, and the best over all values
    length_t      run_ending_at [VALUE_COUNT];
    length_t      best_overall;
    run_lengths_t pending_lengths [$];
    int unsigned  mismatch_count;
    int unsigned  cycle_count;
    bit           idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic length_t longest_below(input value_t v);
        length_t acc;
        acc = '0;
        for (int k = 0; k < int'(v); k++) begin
            if (run_ending_at[k] > acc) acc = run_ending_at[k];
        end
        return acc;
    endfunction

    // predict on every accepted word, check on every accepted result
    always @(posedge i_clk) begin
        length_t      below;
        run_lengths_t want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                below = longest_below(i_sample_value);
                // saturate at the top length
                want.length_ending_here = (below == '1) ? below : below + 1'b1;
                run_ending_at[i_sample_value] = want.length_ending_here;
                if (want.length_ending_here > best_overall)
                    best_overall = want.length_ending_here;
                want.longest_so_far = best_overall;
                pending_lengths.push_back(want);
            end
            if (o_valid && i_ready) begin
                if (pending_lengths.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %0d/%0d",
                        o_length_ending_here, o_longest_so_far));
                end else begin
                    want = pending_lengths.pop_front();
                    if (o_length_ending_here !== want.length_ending_here)
                        report_mismatch($sformatf("length_ending_here got %0d want %0d",
                            o_length_ending_here, want.length_ending_here));
                    if (o_longest_so_far !== want.longest_so_far)
                        report_mismatch($sformatf("longest_so_far got %0d want %0d",
                            o_longest_so_far, want.longest_so_far));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", pending_lengths.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver side: random stall bursts while idling is on
    initial begin
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input int unsigned v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_value <= value_t'(v);
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_lengths.size() != 0);
    endtask

    task automatic test_directed_edges();
        int unsigned seq [] = '{0, 0, VALUE_MAX, VALUE_MAX, 512, 1, 2, 3,
                                VALUE_MAX - 1, VALUE_MAX, VALUE_MAX, 0,
                                1000, 999, 998, 341, 682, 4};
        foreach (seq[k]) send_word(seq[k]);
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_pause_until_drained();
        for (int k = 0; k < 5; k++) send_word($urandom_range(0, VALUE_MAX));
        hold_until_drained();
        for (int k = 0; k < 5; k++) send_word($urandom_range(0, VALUE_MAX));
        hold_until_drained();
    endtask

    // ascending runs with random start and stride grow the overall length;
    // now and then a random word breaks the run
    task automatic send_ascending_runs(input int unsigned n_items);
        int unsigned sent;
        int unsigned v;
        int unsigned run_left;
        sent = 0;
        while (sent < n_items) begin
            v        = $urandom_range(0, VALUE_MAX / 2);
            run_left = $urandom_range(5, 40);
            while (run_left > 0 && v <= VALUE_MAX && sent < n_items) begin
                if ($urandom_range(0, 7) == 0)
                    send_word($urandom_range(0, VALUE_MAX));
                else
                    send_word(v);
                sent++;
                run_left--;
                v += $urandom_range(1, 8);
            end
        end
    endtask

    task automatic test_ascending_runs();
        send_ascending_runs(900);
    endtask

    // uniform values, with some clustered low values for many repeats
    task automatic test_random_values();
        for (int k = 0; k < 420; k++) begin
            if ($urandom_range(0, 3) == 0)
                send_word($urandom_range(0, 15));
            else
                send_word($urandom_range(0, VALUE_MAX));
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        send_ascending_runs(300);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_sample_value = '0;
        idle_on        = 1'b1;
        best_overall   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        foreach (run_ending_at[k]) run_ending_at[k] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_pause_until_drained();
        test_ascending_runs();
        test_random_values();
        test_back_to_back();

        i_valid <= 1'b0;
        while (pending_lengths.size() != 0) @(negedge i_clk);
        repeat (2 * ITEM_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
